### rtl/apu_pkg.sv
// shared constants, types and helpers for the adamw parameter update block
package apu_pkg;

  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 24;

  // configuration register indexes
  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_LEARNING_RATE = 3'd0,
    CFG_BETA_ONE      = 3'd1,
    CFG_BETA_TWO      = 3'd2,
    CFG_EPSILON       = 3'd3,
    CFG_DECAY_RATE    = 3'd4
  } cfg_reg_t;

  localparam logic [23:0] LEARNING_RATE_RST = 24'd16777;
  localparam logic [15:0] BETA_ONE_RST      = 16'd58982;
  localparam logic [15:0] BETA_TWO_RST      = 16'd65470;
  localparam logic [23:0] EPSILON_RST       = 24'd1;
  localparam logic [23:0] DECAY_RATE_RST    = 24'd167772;

  // 1.0 in unsigned q1.31
  localparam logic [31:0] ONE_Q131 = 32'h8000_0000;

  // control from the pipeline to the moment store
  typedef struct packed {
    logic en;
    logic rd_vld;
    logic wr_vld;
  } mom_ctl_t;

  // clamp to signed 32 bit
  function automatic logic [31:0] sat32(input logic signed [63:0] x);
    logic [31:0] res;
    if (x > 64'sd2147483647) begin
      res = 32'h7FFF_FFFF;
    end else if (x < -64'sd2147483648) begin
      res = 32'h8000_0000;
    end else begin
      res = x[31:0];
    end
    return res;
  endfunction

endpackage

### rtl/apu_ram.sv
// generic single-write, single-read ram with registered read data
module apu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // read returns the old word when the same address is written
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### rtl/apu_mom.sv
// first and second moment stores with read-modify-write, forwarding and clear pass
module apu_mom #(
  parameter int ELEMENTS = 65536,
  localparam int AW = (ELEMENTS > 1) ? $clog2(ELEMENTS) : 1
) (
  input  logic                clk,
  input  logic                rst_n,
  input  apu_pkg::mom_ctl_t   ctl,
  input  logic [AW-1:0]       rd_addr,
  input  logic [AW-1:0]       wr_addr,
  input  logic [15:0]         beta_one,
  input  logic [15:0]         beta_two,
  input  logic signed [31:0]  grad,
  input  logic [31:0]         grad_sq,
  output logic signed [31:0]  m_o,
  output logic [31:0]         v_o,
  output logic                busy_o
);

  logic          busy_r;
  logic [AW-1:0] clr_cnt_r;

  logic          fwd_vld_r;
  logic [AW-1:0] fwd_addr_r;
  logic [31:0]   fwd_m_r;
  logic [31:0]   fwd_v_r;

  logic [31:0]   m_rd;
  logic [31:0]   v_rd;
  logic          hit;
  logic signed [31:0] m_old;
  logic [31:0]   v_old;
  logic [16:0]   c1;
  logic [16:0]   c2;
  logic signed [32:0] dm;
  logic signed [32:0] dv;
  logic signed [50:0] pm;
  logic signed [50:0] pv;
  logic signed [31:0] m_new;
  logic [31:0]   v_new;

  logic          we;
  logic [AW-1:0] waddr;
  logic          re;

  // zero both stores once after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b1;
      clr_cnt_r <= '0;
    end else if (busy_r) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
      if (clr_cnt_r == AW'(ELEMENTS - 1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  assign we    = busy_r | (ctl.en & ctl.wr_vld);
  assign waddr = busy_r ? clr_cnt_r : wr_addr;
  assign re    = ctl.en & ctl.rd_vld;

  apu_ram #(.WIDTH(32), .DEPTH(ELEMENTS)) u_m_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (busy_r ? 32'd0 : m_new),
    .re    (re),
    .raddr (rd_addr),
    .rdata (m_rd)
  );

  apu_ram #(.WIDTH(32), .DEPTH(ELEMENTS)) u_v_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (busy_r ? 32'd0 : v_new),
    .re    (re),
    .raddr (rd_addr),
    .rdata (v_rd)
  );

  // last write is missed by a read issued in the same cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_vld_r <= 1'b0;
    end else if (ctl.en) begin
      fwd_vld_r <= ctl.wr_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      fwd_addr_r <= wr_addr;
      fwd_m_r    <= m_new;
      fwd_v_r    <= v_new;
    end
  end

  assign hit   = fwd_vld_r && (fwd_addr_r == wr_addr);
  assign m_old = hit ? fwd_m_r : m_rd;
  assign v_old = hit ? fwd_v_r : v_rd;

  // m + (1-b)(g-m), one product per moment
  assign c1 = 17'h1_0000 - {1'b0, beta_one};
  assign c2 = 17'h1_0000 - {1'b0, beta_two};
  assign dm = {grad[31], grad} - {m_old[31], m_old};
  assign dv = $signed({1'b0, grad_sq}) - $signed({1'b0, v_old});
  assign pm = $signed({1'b0, c1}) * dm;
  assign pv = $signed({1'b0, c2}) * dv;
  assign m_new = m_old + $signed(pm[47:16]);
  assign v_new = v_old + pv[47:16];

  assign m_o    = m_new;
  assign v_o    = v_new;
  assign busy_o = busy_r;

endmodule

### rtl/apu_div.sv
// pipelined restoring divider, one quotient bit per stage, saturating quotient
module apu_div #(
  parameter int NW = 63,
  parameter int DW = 32,
  parameter int QW = 32,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          vld_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  input  logic [SW-1:0] side_i,
  output logic          vld_o,
  output logic [QW-1:0] quo_o,
  output logic [SW-1:0] side_o
);

  logic          vld_r  [QW+1];
  logic          ovf_r  [QW+1];
  logic [QW-1:0] quo_r  [QW+1];
  logic [SW-1:0] side_r [QW+1];
  logic [DW-1:0] rem_r  [QW];
  logic [DW-1:0] den_r  [QW];
  logic [QW-1:0] low_r  [QW];

  logic [DW:0]   trial_w [QW];
  logic [DW+1:0] diff_w  [QW];
  logic          ovf_in;

  // quotient wider than QW bits when the top part already reaches the divisor
  assign ovf_in = DW'(num_i[NW-1:QW]) >= den_i;

  always_comb begin
    for (int k = 0; k < QW; k++) begin
      trial_w[k] = {rem_r[k], low_r[k][QW-1]};
      diff_w[k]  = {1'b0, trial_w[k]} - {2'b00, den_r[k]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= QW; k++) begin
        vld_r[k] <= 1'b0;
      end
    end else if (en) begin
      vld_r[0] <= vld_i;
      for (int k = 0; k < QW; k++) begin
        vld_r[k+1] <= vld_r[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0]  <= DW'(num_i[NW-1:QW]);
      low_r[0]  <= num_i[QW-1:0];
      den_r[0]  <= den_i;
      quo_r[0]  <= '0;
      ovf_r[0]  <= ovf_in;
      side_r[0] <= side_i;
      for (int k = 0; k < QW; k++) begin
        quo_r[k+1]  <= {quo_r[k][QW-2:0], ~diff_w[k][DW+1]};
        ovf_r[k+1]  <= ovf_r[k];
        side_r[k+1] <= side_r[k];
        if (k < QW - 1) begin
          rem_r[k+1] <= diff_w[k][DW+1] ? trial_w[k][DW-1:0] : diff_w[k][DW-1:0];
          low_r[k+1] <= {low_r[k][QW-2:0], 1'b0};
          den_r[k+1] <= den_r[k];
        end
      end
    end
  end

  assign vld_o  = vld_r[QW];
  assign quo_o  = ovf_r[QW] ? '1 : quo_r[QW];
  assign side_o = side_r[QW];

endmodule

### rtl/apu_sqrt.sv
// pipelined integer square root, one result bit per stage
module apu_sqrt #(
  parameter int XW = 56,
  parameter int SW = 1
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               vld_i,
  input  logic [XW-1:0]      x_i,
  input  logic [SW-1:0]      side_i,
  output logic               vld_o,
  output logic [XW/2-1:0]    root_o,
  output logic [SW-1:0]      side_o
);

  localparam int RW = XW / 2;

  logic          vld_r  [RW+1];
  logic [RW-1:0] root_r [RW+1];
  logic [SW-1:0] side_r [RW+1];
  logic [RW:0]   rem_r  [RW];
  logic [XW-1:0] x_r    [RW];

  logic [RW+2:0] cand_w [RW];
  logic [RW+3:0] diff_w [RW];

  // bring in two radicand bits, try root*4+1
  always_comb begin
    for (int k = 0; k < RW; k++) begin
      cand_w[k] = {rem_r[k], x_r[k][XW-1:XW-2]};
      diff_w[k] = {1'b0, cand_w[k]} - {2'b00, root_r[k], 2'b01};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= RW; k++) begin
        vld_r[k] <= 1'b0;
      end
    end else if (en) begin
      vld_r[0] <= vld_i;
      for (int k = 0; k < RW; k++) begin
        vld_r[k+1] <= vld_r[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0]  <= '0;
      x_r[0]    <= x_i;
      root_r[0] <= '0;
      side_r[0] <= side_i;
      for (int k = 0; k < RW; k++) begin
        root_r[k+1] <= {root_r[k][RW-2:0], ~diff_w[k][RW+3]};
        side_r[k+1] <= side_r[k];
        if (k < RW - 1) begin
          rem_r[k+1] <= diff_w[k][RW+3] ? cand_w[k][RW:0] : diff_w[k][RW:0];
          x_r[k+1]   <= {x_r[k][XW-3:0], 2'b00};
        end
      end
    end
  end

  assign vld_o  = vld_r[RW];
  assign root_o = root_r[RW];
  assign side_o = side_r[RW];

endmodule

### rtl/adamw_param_update.sv
// top level of the adamw parameter update pipeline
//
// adamw update of one parameter element per transaction, fully pipelined:
// a new element is accepted every clock cycle unless the output buffer is
// full, and its result passes through 3 front stages, a 33-stage
// bias-correction divider, a 29-stage square root, a product stage, a
// 35-stage step divider, two decay stages and the output buffer. the
// moments live in two ELEMENTS-deep single-port-write rams; each element
// is read one stage after acceptance and written back the next stage, and
// a write-back register forwards the new moments when the same element
// follows immediately. after reset both rams are zeroed by a clearing pass
// during which in_tready stays low; configuration writes are taken at any
// time but belong only to idle periods. a two-entry output buffer lets the
// pipeline keep accepting while one result waits.
module adamw_param_update #(
  parameter int ELEMENTS = 65536
) (
  input  logic        clk,
  input  logic        rst_n,
  // in_tdata: element_index[15:0], gradient[47:16], param_value[79:48]
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [79:0] in_tdata,
  // in_tuser: starts_step
  input  logic        in_tuser,
  // out_tdata: new_param_value[31:0], result_index[47:32]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,
  input  logic        cfg_we,
  input  logic [apu_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [apu_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  localparam int AW = (ELEMENTS > 1) ? $clog2(ELEMENTS) : 1;
  localparam int SIDE2_W = 1 + 32 + 16;
  localparam int SQRT_SIDE_W = 32 + SIDE2_W;
  localparam int SIDE3_W = 1 + SIDE2_W;

  // configuration registers
  logic [23:0] lr_r;
  logic [15:0] b1_r;
  logic [15:0] b2_r;
  logic [23:0] eps_r;
  logic [23:0] decay_r;
  logic [23:0] k_r;
  logic [47:0] kp;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lr_r    <= apu_pkg::LEARNING_RATE_RST;
      b1_r    <= apu_pkg::BETA_ONE_RST;
      b2_r    <= apu_pkg::BETA_TWO_RST;
      eps_r   <= apu_pkg::EPSILON_RST;
      decay_r <= apu_pkg::DECAY_RATE_RST;
    end else if (cfg_we) begin
      unique case (apu_pkg::cfg_reg_t'(cfg_addr))
        apu_pkg::CFG_LEARNING_RATE: lr_r    <= cfg_wdata;
        apu_pkg::CFG_BETA_ONE:      b1_r    <= cfg_wdata[15:0];
        apu_pkg::CFG_BETA_TWO:      b2_r    <= cfg_wdata[15:0];
        apu_pkg::CFG_EPSILON:       eps_r   <= cfg_wdata;
        apu_pkg::CFG_DECAY_RATE:    decay_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // decay coefficient lr*decay, fixed between config writes
  assign kp = lr_r * decay_r;
  always_ff @(posedge clk) begin
    k_r <= kp[47:24];
  end

  // handshake and pipeline advance
  logic       adv;
  logic       in_fire;
  logic       busy;
  logic [1:0] cnt_r;

  assign adv       = (cnt_r != 2'd2);
  assign in_tready = adv & ~busy;
  assign in_fire   = in_tvalid & in_tready;

  logic [15:0]        in_idx;
  logic signed [31:0] in_g;
  logic signed [31:0] in_p;
  assign in_idx = in_tdata[15:0];
  assign in_g   = in_tdata[47:16];
  assign in_p   = in_tdata[79:48];

  // running beta powers, advanced on the first element of a step
  logic [31:0] pow1_r;
  logic [31:0] pow2_r;
  logic [47:0] pow1_prod;
  logic [47:0] pow2_prod;
  assign pow1_prod = pow1_r * b1_r;
  assign pow2_prod = pow2_r * b2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pow1_r <= apu_pkg::ONE_Q131;
      pow2_r <= apu_pkg::ONE_Q131;
    end else if (in_fire && in_tuser) begin
      pow1_r <= pow1_prod[47:16];
      pow2_r <= pow2_prod[47:16];
    end
  end

  // stage a: captured item, ram read issued, gradient squared
  logic               a_vld_r;
  logic [15:0]        a_idx_r;
  logic signed [31:0] a_g_r;
  logic signed [31:0] a_p_r;
  logic               a_inr_r;
  logic [23:0]        a_idx_ext;
  logic signed [63:0] gg;
  logic [31:0]        g2;
  logic [31:0]        bc1_raw;
  logic [31:0]        bc2_raw;
  logic [31:0]        bc1;
  logic [31:0]        bc2;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else if (adv) begin
      a_vld_r <= in_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_idx_r <= in_idx;
      a_g_r   <= in_g;
      a_p_r   <= in_p;
      a_inr_r <= ({9'd0, in_idx} < 25'(ELEMENTS));
    end
  end

  assign a_idx_ext = {8'd0, a_idx_r};
  assign gg        = a_g_r * a_g_r;
  assign g2        = (gg[63:56] != 8'd0) ? 32'hFFFF_FFFF : gg[55:24];
  // no bias correction before the first step
  assign bc1_raw   = apu_pkg::ONE_Q131 - pow1_r;
  assign bc2_raw   = apu_pkg::ONE_Q131 - pow2_r;
  assign bc1       = (bc1_raw == 32'd0) ? apu_pkg::ONE_Q131 : bc1_raw;
  assign bc2       = (bc2_raw == 32'd0) ? apu_pkg::ONE_Q131 : bc2_raw;

  // stage b: moment read data arrives, moments updated and written back
  logic               b_vld_r;
  logic [15:0]        b_idx_r;
  logic signed [31:0] b_g_r;
  logic [31:0]        b_g2_r;
  logic signed [31:0] b_p_r;
  logic               b_inr_r;
  logic [31:0]        b_bc1_r;
  logic [31:0]        b_bc2_r;
  logic [23:0]        b_idx_ext;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
    end else if (adv) begin
      b_vld_r <= a_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_idx_r <= a_idx_r;
      b_g_r   <= a_g_r;
      b_g2_r  <= g2;
      b_p_r   <= a_p_r;
      b_inr_r <= a_inr_r;
      b_bc1_r <= bc1;
      b_bc2_r <= bc2;
    end
  end

  assign b_idx_ext = {8'd0, b_idx_r};

  apu_pkg::mom_ctl_t  mom_ctl;
  logic signed [31:0] m_new;
  logic [31:0]        v_new;

  assign mom_ctl = '{en: adv, rd_vld: a_vld_r & a_inr_r, wr_vld: b_vld_r & b_inr_r};

  apu_mom #(.ELEMENTS(ELEMENTS)) u_mom (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (mom_ctl),
    .rd_addr  (a_idx_ext[AW-1:0]),
    .wr_addr  (b_idx_ext[AW-1:0]),
    .beta_one (b1_r),
    .beta_two (b2_r),
    .grad     (b_g_r),
    .grad_sq  (b_g2_r),
    .m_o      (m_new),
    .v_o      (v_new),
    .busy_o   (busy)
  );

  // stage c: new moments into the bias-correction dividers
  logic               c_vld_r;
  logic signed [31:0] c_m_r;
  logic [31:0]        c_v_r;
  logic [31:0]        c_bc1_r;
  logic [31:0]        c_bc2_r;
  logic signed [31:0] c_p_r;
  logic [15:0]        c_idx_r;
  logic               c_inr_r;
  logic [31:0]        m_abs;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_vld_r <= 1'b0;
    end else if (adv) begin
      c_vld_r <= b_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_m_r   <= m_new;
      c_v_r   <= v_new;
      c_bc1_r <= b_bc1_r;
      c_bc2_r <= b_bc2_r;
      c_p_r   <= b_p_r;
      c_idx_r <= b_idx_r;
      c_inr_r <= b_inr_r;
    end
  end

  assign m_abs = c_m_r[31] ? (32'd0 - c_m_r) : c_m_r;

  logic               d1_vld;
  logic [31:0]        q1;
  logic               d1_neg;
  logic               d2_vld;
  logic [31:0]        q2;
  logic [SIDE2_W-1:0] d2_side;

  // m_hat magnitude = |m| * 2^31 / bc1
  apu_div #(.NW(63), .DW(32), .QW(32), .SW(1)) u_div_m (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (adv),
    .vld_i  (c_vld_r),
    .num_i  ({m_abs, 31'd0}),
    .den_i  (c_bc1_r),
    .side_i (c_m_r[31]),
    .vld_o  (d1_vld),
    .quo_o  (q1),
    .side_o (d1_neg)
  );

  // v_hat = v * 2^31 / bc2, saturates to all ones
  apu_div #(.NW(63), .DW(32), .QW(32), .SW(SIDE2_W)) u_div_v (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (adv),
    .vld_i  (c_vld_r),
    .num_i  ({c_v_r, 31'd0}),
    .den_i  (c_bc2_r),
    .side_i ({c_inr_r, c_p_r, c_idx_r}),
    .vld_o  (d2_vld),
    .quo_o  (q2),
    .side_o (d2_side)
  );

  // signed m_hat with saturation
  logic [31:0] mh;
  always_comb begin
    if (d1_neg) begin
      mh = q1[31] ? 32'h8000_0000 : (32'd0 - q1);
    end else begin
      mh = q1[31] ? 32'h7FFF_FFFF : q1;
    end
  end

  logic                   sq_vld;
  logic [27:0]            root;
  logic [SQRT_SIDE_W-1:0] sq_side;

  // sqrt(v_hat) in q4.24
  apu_sqrt #(.XW(56), .SW(SQRT_SIDE_W)) u_sqrt (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (adv),
    .vld_i  (d1_vld & d2_vld),
    .x_i    ({q2, 24'd0}),
    .side_i ({mh, d2_side}),
    .vld_o  (sq_vld),
    .root_o (root),
    .side_o (sq_side)
  );

  // stage f: denominator and lr * m_hat
  logic signed [31:0] sq_mh;
  logic [28:0]        d_raw;
  logic signed [56:0] lrm;
  logic [55:0]        lrm_mag;

  assign sq_mh   = sq_side[SQRT_SIDE_W-1:SIDE2_W];
  assign d_raw   = {1'b0, root} + {5'd0, eps_r};
  assign lrm     = $signed({1'b0, lr_r}) * sq_mh;
  assign lrm_mag = lrm[56] ? 56'(-lrm) : lrm[55:0];

  logic               f_vld_r;
  logic [28:0]        f_d_r;
  logic [55:0]        f_mag_r;
  logic               f_neg_r;
  logic [SIDE2_W-1:0] f_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_vld_r <= 1'b0;
    end else if (adv) begin
      f_vld_r <= sq_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // zero denominator counts as one lsb
      f_d_r    <= (d_raw == 29'd0) ? 29'd1 : d_raw;
      f_mag_r  <= lrm_mag;
      f_neg_r  <= lrm[56];
      f_side_r <= sq_side[SIDE2_W-1:0];
    end
  end

  logic               d3_vld;
  logic [33:0]        q3;
  logic [SIDE3_W-1:0] d3_side;

  // adaptive step magnitude, saturated well past the value range
  apu_div #(.NW(56), .DW(29), .QW(34), .SW(SIDE3_W)) u_div_step (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (adv),
    .vld_i  (f_vld_r),
    .num_i  (f_mag_r),
    .den_i  (f_d_r),
    .side_i ({f_neg_r, f_side_r}),
    .vld_o  (d3_vld),
    .quo_o  (q3),
    .side_o (d3_side)
  );

  // stage h: value minus step
  logic               s_neg;
  logic               s_inr;
  logic signed [31:0] s_p;
  logic [15:0]        s_idx;
  logic signed [35:0] step;
  logic signed [35:0] diff1;

  assign {s_neg, s_inr, s_p, s_idx} = d3_side;
  assign step  = s_neg ? -$signed({2'b00, q3}) : $signed({2'b00, q3});
  assign diff1 = $signed({{4{s_p[31]}}, s_p}) - step;

  logic               h_vld_r;
  logic signed [31:0] h_p1_r;
  logic signed [31:0] h_p_r;
  logic               h_inr_r;
  logic [15:0]        h_idx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h_vld_r <= 1'b0;
    end else if (adv) begin
      h_vld_r <= d3_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      h_p1_r  <= apu_pkg::sat32(64'(diff1));
      h_p_r   <= s_p;
      h_inr_r <= s_inr;
      h_idx_r <= s_idx;
    end
  end

  // stage i: decay product on the updated value
  logic               i_vld_r;
  logic signed [56:0] i_prod_r;
  logic signed [31:0] i_p1_r;
  logic signed [31:0] i_p_r;
  logic               i_inr_r;
  logic [15:0]        i_idx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      i_vld_r <= 1'b0;
    end else if (adv) begin
      i_vld_r <= h_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      i_prod_r <= $signed({1'b0, k_r}) * h_p1_r;
      i_p1_r   <= h_p1_r;
      i_p_r    <= h_p_r;
      i_inr_r  <= h_inr_r;
      i_idx_r  <= h_idx_r;
    end
  end

  logic signed [32:0] decay_sh;
  logic signed [33:0] diff2;
  logic [31:0]        res_val;
  logic [47:0]        res;

  assign decay_sh = i_prod_r[56:24];
  assign diff2    = $signed({{2{i_p1_r[31]}}, i_p1_r}) - $signed({decay_sh[32], decay_sh});
  // out-of-range index passes the value through
  assign res_val  = i_inr_r ? apu_pkg::sat32(64'(diff2)) : i_p_r;
  assign res      = {i_idx_r, res_val};

  // two-entry output buffer
  logic        push;
  logic        pop;
  logic [47:0] slot0_r;
  logic [47:0] slot1_r;

  assign push = adv & i_vld_r;
  assign pop  = out_tvalid & out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= 2'(cnt_r + {1'b0, push} - {1'b0, pop});
    end
  end

  always_ff @(posedge clk) begin
    if (push && (cnt_r == 2'd0 || (cnt_r == 2'd1 && pop))) begin
      slot0_r <= res;
    end else if (pop && cnt_r == 2'd2) begin
      slot0_r <= slot1_r;
    end
    if (push && cnt_r == 2'd1 && !pop) begin
      slot1_r <= res;
    end
  end

  assign out_tvalid = (cnt_r != 2'd0);
  assign out_tdata  = slot0_r;

endmodule

### rtl/apu_chk.sv
// port-level checks for the adamw parameter update block
module apu_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [47:0] out_tdata
);

  // reset empties the output and starts the clearing pass
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && !in_tready)
    else $error("output or input open right after reset");

  // a waiting result keeps its data
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  // input closes only when the output buffer fills behind a stalled result
  a_ready_drop: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $fell(in_tready) |-> $past(out_tvalid && !out_tready))
    else $error("in_tready dropped without output backpressure");

endmodule

bind adamw_param_update apu_chk u_apu_chk (.*);

### tb/sv/tb_adamw_param_update.sv
// testbench for the adamw parameter update block: directed table plus random stream
module tb_adamw_param_update;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NELEM = 65536;
  // well past the pipeline depth, so stray results would show up
  localparam int DRAIN_CYCLES = 200;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [79:0] in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_addr = '0;
  logic [23:0] cfg_wdata = '0;

  adamw_param_update #(.ELEMENTS(NELEM)) dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // one input transaction and its expected outcome
  typedef struct {
    logic [15:0] idx;
    logic [31:0] grad;
    logic [31:0] param;
    logic        start;
    logic        has_exp; // typed-in expected value present
    logic [31:0] exp_val;
  } upd_item_t;

  typedef struct {
    logic [31:0] val;
    logic [15:0] idx;
  } upd_result_t;

  // predictor copy of the configuration and optimizer state
  logic [23:0] lr_q, eps_q, decay_q;
  logic [15:0] b1_q, b2_q;
  logic [31:0] b1_pow, b2_pow, steps_seen;
  logic signed [31:0] m_store [int];
  logic [31:0] v_store [int];

  upd_result_t pending_results[$];
  int errors = 0;
  int results_seen = 0;
  int sender_idle_pct = 0;
  int recv_stall_pct = 0;
  int phase_pauses = 0;

  // fixed touched set so moments build up over several steps
  logic [15:0] hot_idx [16];

  function automatic logic signed [63:0] floor_rshift(logic signed [63:0] x, int s);
    return x >>> s; // arithmetic shift rounds toward minus infinity
  endfunction

  function automatic logic signed [63:0] clamp32(logic signed [63:0] x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  function automatic logic [63:0] int_sqrt(logic [63:0] x);
    logic [63:0] res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x = x - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // advances the predictor state and returns the new parameter value
  function automatic logic [31:0] adamw_predict(upd_item_t it);
    logic signed [63:0] g, p, m, mh, step, p1, k, p2;
    logic [63:0] bc1, bc2, g2, v, vh, d, vm_old;
    logic signed [63:0] m_old;
    g = $signed(it.grad);
    p = $signed(it.param);
    if (it.start) begin
      steps_seen = steps_seen + 1;
      b1_pow = 32'((64'(b1_pow) * b1_q) >> 16);
      b2_pow = 32'((64'(b2_pow) * b2_q) >> 16);
    end
    bc1 = 64'(apu_pkg::ONE_Q131) - b1_pow;
    bc2 = 64'(apu_pkg::ONE_Q131) - b2_pow;
    if (bc1 == 0) bc1 = 64'(apu_pkg::ONE_Q131);
    if (bc2 == 0) bc2 = 64'(apu_pkg::ONE_Q131);
    m_old = m_store.exists(it.idx) ? 64'(m_store[it.idx]) : 64'sd0;
    vm_old = v_store.exists(it.idx) ? 64'(v_store[it.idx]) : 64'd0;
    m = floor_rshift($signed({48'd0, b1_q}) * m_old
                     + $signed(64'd65536 - b1_q) * g, 16);
    m_store[it.idx] = m[31:0];
    g2 = 64'(g * g) >> 24;
    if (g2 > 64'hFFFF_FFFF) g2 = 64'hFFFF_FFFF;
    v = (64'(b2_q) * vm_old + (64'd65536 - b2_q) * g2) >> 16;
    v_store[it.idx] = v[31:0];
    mh = clamp32((m * 64'sh8000_0000) / $signed(bc1));
    vh = (v * 64'h8000_0000) / bc2;
    if (vh > 64'hFFFF_FFFF) vh = 64'hFFFF_FFFF;
    d = int_sqrt(vh << 24) + eps_q;
    if (d == 0) d = 1;
    step = ($signed({40'd0, lr_q}) * mh) / $signed(d);
    p1 = clamp32(p - step);
    k = $signed(64'((64'(lr_q) * decay_q) >> 24));
    p2 = clamp32(p1 - floor_rshift(k * p1, 24));
    return p2[31:0];
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
    errors++;
  endtask

  // result checker and receiver stalls
  always @(posedge clk) begin
    if (rst_n) begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
      if (out_tvalid && out_tready) begin
        results_seen++;
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected result", {16'd0, out_tdata[47:32]}, '0);
        end else begin
          upd_result_t e;
          e = pending_results.pop_front();
          if (out_tdata[31:0] !== e.val)
            report_mismatch("new_param_value", out_tdata[31:0], e.val);
          if (out_tdata[47:32] !== e.idx)
            report_mismatch("result_index", {16'd0, out_tdata[47:32]}, {16'd0, e.idx});
        end
      end
    end
  end

  // sends one transaction, queueing its expected result on acceptance;
  // tvalid stays high afterwards so items can follow back to back
  task automatic send_update(upd_item_t it);
    upd_result_t r;
    if ($urandom_range(99) < sender_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < sender_idle_pct) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {it.param, it.grad, it.idx};
    in_tuser <= it.start;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    r.idx = it.idx;
    r.val = adamw_predict(it);
    if (it.has_exp && r.val !== it.exp_val)
      report_mismatch("table value vs predictor", r.val, it.exp_val);
    pending_results = {pending_results, r};
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // write enable stays high between writes, dropped once a group is done
  task automatic write_reg(apu_pkg::cfg_reg_t r, logic [23:0] val);
    cfg_we <= 1'b1;
    cfg_addr <= r;
    cfg_wdata <= val;
    @(posedge clk);
    case (r)
      apu_pkg::CFG_LEARNING_RATE: lr_q = val;
      apu_pkg::CFG_BETA_ONE:      b1_q = val[15:0];
      apu_pkg::CFG_BETA_TWO:      b2_q = val[15:0];
      apu_pkg::CFG_EPSILON:       eps_q = val;
      apu_pkg::CFG_DECAY_RATE:    decay_q = val;
      default: ;
    endcase
  endtask

  function automatic logic [31:0] rand_value(int mode);
    case (mode)
      0: return $urandom();
      1: return 32'($signed($urandom_range(33554432)) - 16777216); // around +/-1.0
      2: return 32'($signed($urandom_range(2000)) - 1000);
      default: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
    endcase
  endfunction

  function automatic upd_item_t rand_item(bit start);
    upd_item_t it;
    it.idx = ($urandom_range(3) != 0) ? hot_idx[$urandom_range(15)] : 16'($urandom());
    it.grad = rand_value($urandom_range(3));
    it.param = rand_value($urandom_range(3));
    it.start = start;
    it.has_exp = 1'b0;
    it.exp_val = '0;
    return it;
  endfunction

  // bursts of steps of random length, mostly on the hot elements, with occasional random indexes
  task automatic random_phase(int n_items, int idle, int stall);
    int sent;
    sender_idle_pct = idle;
    recv_stall_pct = stall;
    sent = 0;
    while (sent < n_items) begin
      int len;
      len = $urandom_range(24, 4);
      for (int i = 0; i < len && sent < n_items; i++) begin
        send_update(rand_item(i == 0));
        sent++;
      end
    end
  endtask

  upd_item_t dir_tbl[$];

  task automatic add_row(logic [15:0] idx, logic [31:0] g, logic [31:0] p, logic s,
                         logic he, logic [31:0] ev);
    upd_item_t it;
    it.idx = idx; it.grad = g; it.param = p; it.start = s;
    it.has_exp = he; it.exp_val = ev;
    dir_tbl = {dir_tbl, it};
  endtask

  initial begin
    lr_q = apu_pkg::LEARNING_RATE_RST; b1_q = apu_pkg::BETA_ONE_RST;
    b2_q = apu_pkg::BETA_TWO_RST;
    eps_q = apu_pkg::EPSILON_RST; decay_q = apu_pkg::DECAY_RATE_RST;
    b1_pow = apu_pkg::ONE_Q131; b2_pow = apu_pkg::ONE_Q131; steps_seen = 0;
    for (int i = 0; i < 16; i++) hot_idx[i] = 16'($urandom());
    hot_idx[0] = 16'd0; hot_idx[1] = 16'hFFFF;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table: zero gradient before any step leaves only the decay,
    // k = (16777*167772)>>24 = 167, so zero stays zero and 1.0 shrinks by 167 lsb
    add_row(16'd5, 32'd0, 32'd0, 1'b0, 1'b1, 32'd0);
    add_row(16'd6, 32'd0, 32'h0100_0000, 1'b0, 1'b1, 32'h0100_0000 - 32'd167);
    add_row(16'hFFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, 1'b0, '0);
    add_row(16'h0000, 32'h8000_0000, 32'h8000_0000, 1'b1, 1'b0, '0);
    add_row(16'h0000, 32'h7FFF_FFFF, 32'h0, 1'b0, 1'b0, '0);
    add_row(16'h0001, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b0, '0);
    add_row(16'h8000, 32'h0100_0000, 32'h0100_0000, 1'b0, 1'b0, '0);
    add_row(16'h8000, 32'h0100_0000, 32'h0100_0000, 1'b0, 1'b0, '0); // back to back
    add_row(16'h5555, 32'hAAAA_AAAA, 32'h5555_5555, 1'b1, 1'b0, '0);
    add_row(16'hAAAA, 32'h5555_5555, 32'hAAAA_AAAA, 1'b0, 1'b0, '0);
    sender_idle_pct = 0; recv_stall_pct = 0;
    foreach (dir_tbl[i]) send_update(dir_tbl[i]);
    wait_drained();

    // zero denominator: epsilon and decay off and a fresh element with zero gradient
    write_reg(apu_pkg::CFG_EPSILON, 24'd0);
    write_reg(apu_pkg::CFG_DECAY_RATE, 24'd0);
    cfg_we <= 1'b0;
    add_row(16'h1234, 32'd0, 32'h0000_1000, 1'b0, 1'b1, 32'h0000_1000);
    send_update(dir_tbl[$]);
    add_row(16'h1234, 32'h0000_0001, 32'h0000_1000, 1'b0, 1'b0, '0);
    send_update(dir_tbl[$]);
    wait_drained();

    // random phases over several configurations, extremes included
    write_reg(apu_pkg::CFG_LEARNING_RATE, 24'hFFFFFF);
    write_reg(apu_pkg::CFG_BETA_ONE, 24'h00FFFF);
    write_reg(apu_pkg::CFG_BETA_TWO, 24'h000000);
    write_reg(apu_pkg::CFG_EPSILON, 24'hFFFFFF);
    write_reg(apu_pkg::CFG_DECAY_RATE, 24'hFFFFFF);
    cfg_we <= 1'b0;
    random_phase(110, 0, 0);
    wait_drained();
    phase_pauses++;

    write_reg(apu_pkg::CFG_LEARNING_RATE, 24'd0);
    write_reg(apu_pkg::CFG_BETA_ONE, 24'd0);
    write_reg(apu_pkg::CFG_BETA_TWO, 24'hFFFF);
    write_reg(apu_pkg::CFG_EPSILON, 24'd0);
    write_reg(apu_pkg::CFG_DECAY_RATE, 24'd0);
    cfg_we <= 1'b0;
    random_phase(110, 56, 0);
    wait_drained();
    phase_pauses++;

    write_reg(apu_pkg::CFG_LEARNING_RATE, 24'($urandom()));
    write_reg(apu_pkg::CFG_BETA_ONE, 24'($urandom()));
    write_reg(apu_pkg::CFG_BETA_TWO, 24'($urandom()));
    write_reg(apu_pkg::CFG_EPSILON, 24'($urandom_range(255)));
    write_reg(apu_pkg::CFG_DECAY_RATE, 24'($urandom()));
    cfg_we <= 1'b0;
    random_phase(115, 0, 56);
    wait_drained();
    phase_pauses++;

    write_reg(apu_pkg::CFG_LEARNING_RATE, apu_pkg::LEARNING_RATE_RST);
    write_reg(apu_pkg::CFG_BETA_ONE, 24'(apu_pkg::BETA_ONE_RST));
    write_reg(apu_pkg::CFG_BETA_TWO, 24'(apu_pkg::BETA_TWO_RST));
    write_reg(apu_pkg::CFG_EPSILON, apu_pkg::EPSILON_RST);
    write_reg(apu_pkg::CFG_DECAY_RATE, apu_pkg::DECAY_RATE_RST);
    cfg_we <= 1'b0;
    random_phase(115, 25, 25);
    wait_drained();

    $display("covered %0d results over %0d optimizer steps, %0d idle pauses",
             results_seen, steps_seen, phase_pauses);
    if (errors == 0) begin
      $display("PASS adamw_param_update");
    end else begin
      $display("FAIL adamw_param_update");
    end
    $finish;
  end

  // run limit, including the moment clearing pass after reset
  initial begin
    #20ms;
    $display("FAIL adamw_param_update");
    $finish;
  end

endmodule
